@@ rtl/core/avc_pkg.sv @@
package avc_pkg;

   localparam logic [1:0] OP_CHECK  = 2'd0;
   localparam logic [1:0] OP_FILL   = 2'd1;
   localparam logic [1:0] OP_FLUSH  = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic CSR_IDX_ENFORCING = 1'b0;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] subject_id;
      logic [31:0] target_id;
      logic [15:0] object_class;
      logic [31:0] requested_perms;
      logic [31:0] allowed_vector;
      logic [31:0] decided_vector;
      logic [31:0] audit_allow_vector;
      logic [31:0] audit_deny_vector;
      logic [31:0] new_context_in;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic        granted;
      logic [31:0] denied_bits;
      logic [31:0] audited_bits;
      logic        audit_is_denial;
      logic [31:0] new_context_out;
   } rsp_type;

   typedef struct packed {
      logic [31:0] subject;
      logic [31:0] target;
      logic [15:0] obj_class;
      logic [31:0] allowed;
      logic [31:0] decided;
      logic [31:0] audit_allow;
      logic [31:0] audit_deny;
      logic [31:0] create_ctx;
   } entry_type;

   function automatic logic [31:0] hash_key(input logic [31:0] s, input logic [31:0] t,
                                            input logic [15:0] c);
      return s ^ {t[29:0], 2'b00} ^ {16'h0000, c};
   endfunction

   function automatic rsp_type decide(input logic [31:0] perms, input logic [31:0] allowed,
                                      input logic [31:0] aallow, input logic [31:0] adeny,
                                      input logic enforcing);
      rsp_type     r;
      logic [31:0] den;
      den               = perms & ~allowed;
      r                 = '0;
      r.denied_bits     = den;
      r.audited_bits    = (den != 32'h0) ? (den & adeny) : (perms & aallow);
      r.audit_is_denial = (den != 32'h0);
      r.granted         = !(((perms == 32'h0) || (den != 32'h0)) && enforcing);
      return r;
   endfunction

endpackage

@@ rtl/core/avc_intf.sv @@
interface avc_req_if;
   logic             valid;
   logic             ready;
   avc_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface avc_rsp_if;
   logic             valid;
   logic             ready;
   avc_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/core/avc_hash.sv @@
module avc_hash #(
   parameter int BUCKETS = 512,
   localparam int BW = $clog2(BUCKETS)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [31:0]   key,
   output logic          done,
   output logic [BW-1:0] bucket
);

   // key mod BUCKETS by reciprocal multiplication, exact for any 32-bit key
   localparam logic [63:0] RECIP = ((64'd1 << (32 + BW)) + 64'(BUCKETS) - 64'd1) /
                                   64'(BUCKETS);
   localparam logic [32:0] MUL = RECIP[32:0];

   localparam logic [1:0] PH_MUL = 2'd0;
   localparam logic [1:0] PH_QUO = 2'd1;
   localparam logic [1:0] PH_REM = 2'd2;

   logic [31:0]   key_ff, key_in;
   logic [1:0]    phase_ff, phase_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [48:0]   plo_ff, plo_in;
   logic [48:0]   phi_ff, phi_in;
   logic [31:0]   quo_ff, quo_in;
   logic [BW-1:0] rem_ff, rem_in;
   logic [64:0]   sum;
   logic [31:0]   qb;

   always_comb begin
      sum      = {16'h0000, plo_ff} + {phi_ff, 16'h0000};
      qb       = quo_ff * 32'(BUCKETS);
      key_in   = key_ff;
      phase_in = phase_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      plo_in   = plo_ff;
      phi_in   = phi_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      if (start) begin
         key_in   = key;
         phase_in = PH_MUL;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         phase_in = phase_ff + 2'd1;
         case (phase_ff)
            PH_MUL: begin
               plo_in = {33'h0, key_ff[15:0]} * {16'h0000, MUL};
               phi_in = {33'h0, key_ff[31:16]} * {16'h0000, MUL};
            end
            PH_QUO: begin
               quo_in = 32'(sum >> (32 + BW));
            end
            PH_REM: begin
               rem_in  = BW'(key_ff - qb);
               busy_in = 1'b0;
               done_in = 1'b1;
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      key_ff   <= key_in;
      phase_ff <= phase_in;
      plo_ff   <= plo_in;
      phi_ff   <= phi_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
   end

   assign done   = done_ff;
   assign bucket = rem_ff;

endmodule

@@ rtl/core/access_vector_cache.sv @@
// channel  | dir | handshake             | payload
// req_ch   | in  | valid/ready           | op, key, requested perms, fill vectors
// rsp_ch   | out | valid/ready           | hit, grant, denied/audited bits, context
// csr_*    | in  | APB write, pready = 1 | enforcing at byte address 0
// One transaction at a time: accept, bucket hashing, a bucket head read, then one
// compare per chain node, then the result is posted. A fill that inserts adds a
// free-node read and an insert write; reclaim, when the free list is empty, sweeps
// buckets from the hint, clearing the hot bit of hot nodes and unlinking cold nodes
// onto the free list. Reset and flush run a relink pass over the bucket and link memories, req_ch.ready low meanwhile.
// Stalls on rsp_ch hold the finished result in the output register.
module access_vector_cache #(
   parameter int BUCKETS = 512,
   parameter int NODES   = 1024
) (
   input  logic        clock,
   input  logic        reset,
   avc_req_if.sink     req_ch,
   avc_rsp_if.source   rsp_ch,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int BW   = $clog2(BUCKETS);
   localparam int NW   = $clog2(NODES);
   localparam int PW   = $clog2(NODES + 1);
   localparam int MAXN = (BUCKETS > NODES) ? BUCKETS : NODES;
   localparam int CW   = $clog2(MAXN);
   localparam logic [PW-1:0] NIL = PW'(NODES);

   localparam logic [3:0] ST_CLEAR   = 4'd0;
   localparam logic [3:0] ST_IDLE    = 4'd1;
   localparam logic [3:0] ST_HASH    = 4'd2;
   localparam logic [3:0] ST_HEAD    = 4'd3;
   localparam logic [3:0] ST_CMP     = 4'd4;
   localparam logic [3:0] ST_SW_HEAD = 4'd5;
   localparam logic [3:0] ST_SW_NODE = 4'd6;
   localparam logic [3:0] ST_SW_FREE = 4'd7;
   localparam logic [3:0] ST_INS_RD  = 4'd8;
   localparam logic [3:0] ST_INS_WR  = 4'd9;
   localparam logic [3:0] ST_DONE    = 4'd10;

   logic [3:0]         state_ff, state_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               pend_ff, pend_in;
   logic               enf_ff;
   avc_pkg::req_type   req_ff, req_in;
   avc_pkg::rsp_type   res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   avc_pkg::rsp_type   rsp_data_ff, rsp_data_in;
   logic [BW-1:0]      bucket_ff, bucket_in;
   logic [BW-1:0]      hint_ff, hint_in;
   logic [PW-1:0]      free_ff, free_in;
   logic [PW-1:0]      cur_ff, cur_in;
   logic [PW-1:0]      prev_ff, prev_in;
   logic [PW-1:0]      nxt_ff, nxt_in;

   logic [PW-1:0]      head_mem [BUCKETS];
   logic [PW-1:0]      link_mem [NODES];
   logic               hot_mem [NODES];
   avc_pkg::entry_type entry_mem [NODES];

   logic [BW-1:0]      head_raddr, head_waddr;
   logic [PW-1:0]      head_wdata, head_rd_ff;
   logic               head_we;
   logic [NW-1:0]      node_raddr, link_waddr, hot_waddr;
   logic [PW-1:0]      link_wdata, link_rd_ff;
   logic               link_we, hot_we, hot_wdata, hot_rd_ff, entry_we;
   avc_pkg::entry_type entry_wdata, entry_rd_ff;

   logic               hash_start, hash_done;
   logic [BW-1:0]      hash_bucket;
   logic               req_take, csr_wr;
   logic [31:0]        match_perms;
   logic               match;
   logic [BW-1:0]      hint_next;

   avc_hash #(.BUCKETS(BUCKETS)) u_hash (
      .clock  (clock),
      .reset  (reset),
      .start  (hash_start),
      .key    (avc_pkg::hash_key(req_in.subject_id, req_in.target_id, req_in.object_class)),
      .done   (hash_done),
      .bucket (hash_bucket)
   );

   assign req_take   = req_ch.valid && req_ch.ready;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == avc_pkg::CSR_IDX_ENFORCING) ? {31'h0, enf_ff} : 32'h0;

   assign req_ch.ready   = (state_ff == ST_IDLE);
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;

   assign match_perms = (req_ff.op == avc_pkg::OP_CHECK) ? req_ff.requested_perms
                                                          : req_ff.decided_vector;
   assign match = (entry_rd_ff.subject == req_ff.subject_id) &&
                  (entry_rd_ff.target == req_ff.target_id) &&
                  (entry_rd_ff.obj_class == req_ff.object_class) &&
                  ((match_perms & entry_rd_ff.decided) == match_perms);
   assign hint_next = (hint_ff == BW'(BUCKETS - 1)) ? '0 : hint_ff + 1'b1;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pend_in      = pend_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      bucket_in    = bucket_ff;
      hint_in      = hint_ff;
      free_in      = free_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      nxt_in       = nxt_ff;
      hash_start   = 1'b0;
      head_raddr   = hash_bucket;
      head_we      = 1'b0;
      head_waddr   = bucket_ff;
      head_wdata   = NIL;
      node_raddr   = cur_ff[NW-1:0];
      link_we      = 1'b0;
      link_waddr   = cur_ff[NW-1:0];
      link_wdata   = NIL;
      hot_we       = 1'b0;
      hot_waddr    = cur_ff[NW-1:0];
      hot_wdata    = 1'b0;
      entry_we     = 1'b0;
      entry_wdata  = '{subject: req_ff.subject_id, target: req_ff.target_id,
                       obj_class: req_ff.object_class, allowed: req_ff.allowed_vector,
                       decided: req_ff.decided_vector, audit_allow: req_ff.audit_allow_vector,
                       audit_deny: req_ff.audit_deny_vector, create_ctx: req_ff.new_context_in};

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            if ({1'b0, cnt_ff} < (CW+1)'(BUCKETS)) begin
               head_we    = 1'b1;
               head_waddr = cnt_ff[BW-1:0];
            end
            if ({1'b0, cnt_ff} < (CW+1)'(NODES)) begin
               link_we    = 1'b1;
               link_waddr = cnt_ff[NW-1:0];
               link_wdata = (cnt_ff == '0) ? NIL : PW'(cnt_ff - 1'b1);
               hot_we     = 1'b1;
               hot_waddr  = cnt_ff[NW-1:0];
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(MAXN - 1)) begin
               free_in  = PW'(NODES - 1);
               state_in = pend_ff ? ST_DONE : ST_IDLE;
               pend_in  = 1'b0;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               req_in = req_ch.payload;
               res_in = '0;
               if (req_ch.payload.op == avc_pkg::OP_FILL) begin
                  res_in = avc_pkg::decide(req_ch.payload.requested_perms,
                                           req_ch.payload.allowed_vector,
                                           req_ch.payload.audit_allow_vector,
                                           req_ch.payload.audit_deny_vector, enf_ff);
                  res_in.new_context_out = req_ch.payload.new_context_in;
               end
               case (req_ch.payload.op)
                  avc_pkg::OP_CHECK, avc_pkg::OP_FILL: state_in = ST_HASH;
                  avc_pkg::OP_FLUSH: begin
                     state_in = ST_CLEAR;
                     cnt_in   = '0;
                     pend_in  = 1'b1;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_HASH: begin
            if (hash_done) begin
               bucket_in = hash_bucket;
               state_in  = ST_HEAD;
            end
         end
         ST_HEAD: begin
            cur_in = head_rd_ff;
            if (head_rd_ff == NIL) begin
               if (req_ff.op == avc_pkg::OP_CHECK) begin
                  state_in = ST_DONE;
               end else if (free_ff == NIL) begin
                  head_raddr = hint_ff;
                  prev_in    = NIL;
                  state_in   = ST_SW_HEAD;
               end else begin
                  state_in = ST_INS_RD;
               end
            end else begin
               node_raddr = head_rd_ff[NW-1:0];
               state_in   = ST_CMP;
            end
         end
         ST_CMP: begin
            if (match) begin
               if (req_ff.op == avc_pkg::OP_CHECK) begin
                  res_in = avc_pkg::decide(req_ff.requested_perms, entry_rd_ff.allowed,
                                           entry_rd_ff.audit_allow, entry_rd_ff.audit_deny,
                                           enf_ff);
                  res_in.hit             = 1'b1;
                  res_in.new_context_out = entry_rd_ff.create_ctx;
               end
               state_in = ST_DONE;
            end else begin
               cur_in = link_rd_ff;
               if (link_rd_ff == NIL) begin
                  if (req_ff.op == avc_pkg::OP_CHECK) begin
                     state_in = ST_DONE;
                  end else if (free_ff == NIL) begin
                     head_raddr = hint_ff;
                     prev_in    = NIL;
                     state_in   = ST_SW_HEAD;
                  end else begin
                     state_in = ST_INS_RD;
                  end
               end else begin
                  node_raddr = link_rd_ff[NW-1:0];
               end
            end
         end
         ST_SW_HEAD: begin
            cur_in = head_rd_ff;
            if (head_rd_ff == NIL) begin
               hint_in    = hint_next;
               head_raddr = hint_next;
               if (free_ff != NIL) begin
                  state_in = ST_INS_RD;
               end
            end else begin
               node_raddr = head_rd_ff[NW-1:0];
               state_in   = ST_SW_NODE;
            end
         end
         ST_SW_NODE: begin
            if (hot_rd_ff) begin
               hot_we  = 1'b1;
               prev_in = cur_ff;
               cur_in  = link_rd_ff;
               if (link_rd_ff == NIL) begin
                  hint_in    = hint_next;
                  head_raddr = hint_next;
                  prev_in    = NIL;
                  state_in   = (free_ff != NIL) ? ST_INS_RD : ST_SW_HEAD;
               end else begin
                  node_raddr = link_rd_ff[NW-1:0];
               end
            end else begin
               if (prev_ff == NIL) begin
                  head_we    = 1'b1;
                  head_waddr = hint_ff;
                  head_wdata = link_rd_ff;
               end else begin
                  link_we    = 1'b1;
                  link_waddr = prev_ff[NW-1:0];
                  link_wdata = link_rd_ff;
               end
               nxt_in   = link_rd_ff;
               state_in = ST_SW_FREE;
            end
         end
         ST_SW_FREE: begin
            link_we    = 1'b1;
            link_wdata = free_ff;
            free_in    = cur_ff;
            cur_in     = nxt_ff;
            if (nxt_ff == NIL) begin
               hint_in  = hint_next;
               prev_in  = NIL;
               state_in = ST_INS_RD;
            end else begin
               node_raddr = nxt_ff[NW-1:0];
               state_in   = ST_SW_NODE;
            end
         end
         ST_INS_RD: begin
            head_raddr = bucket_ff;
            node_raddr = free_ff[NW-1:0];
            state_in   = (free_ff == NIL) ? ST_DONE : ST_INS_WR;
         end
         ST_INS_WR: begin
            free_in    = link_rd_ff;
            entry_we   = 1'b1;
            hot_we     = 1'b1;
            hot_waddr  = free_ff[NW-1:0];
            hot_wdata  = 1'b1;
            link_we    = 1'b1;
            link_waddr = free_ff[NW-1:0];
            link_wdata = head_rd_ff;
            head_we    = 1'b1;
            head_wdata = free_ff;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (state_ff == ST_IDLE && req_take &&
          (req_ch.payload.op == avc_pkg::OP_CHECK || req_ch.payload.op == avc_pkg::OP_FILL)) begin
         hash_start = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[head_waddr] <= head_wdata;
      end
      head_rd_ff <= head_mem[head_raddr];
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      link_rd_ff <= link_mem[node_raddr];
      if (hot_we) begin
         hot_mem[hot_waddr] <= hot_wdata;
      end
      hot_rd_ff <= hot_mem[node_raddr];
      if (entry_we) begin
         entry_mem[free_ff[NW-1:0]] <= entry_wdata;
      end
      entry_rd_ff <= entry_mem[node_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         enf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hint_ff      <= '0;
         free_ff      <= NIL;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         hint_ff      <= hint_in;
         free_ff      <= free_in;
         if (csr_wr && csr_paddr[2] == avc_pkg::CSR_IDX_ENFORCING) begin
            enf_ff <= csr_pwdata[0];
         end
      end
      req_ff      <= req_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      bucket_ff   <= bucket_in;
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      nxt_ff      <= nxt_in;
   end

   a_free_range: assert property (@(posedge clock) disable iff (reset) free_ff <= NIL)
      else $error("free list head out of range");
   a_hint_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, hint_ff} < (BW+1)'(BUCKETS))
      else $error("sweep hint out of range");
   a_flush_clear: assert property (@(posedge clock) disable iff (reset)
      req_take && req_ch.payload.op == avc_pkg::OP_FLUSH |=> state_ff == ST_CLEAR)
      else $error("flush did not start relink pass");
   a_hit_check: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE && res_ff.hit |-> req_ff.op == avc_pkg::OP_CHECK)
      else $error("hit reported for non-check transaction");

endmodule
